### hdl/ppne_pkg.sv
// Shared types and constants for the point-to-plane normal-equation unit.
// Holds the Jacobian row record passed from the front end to the back end
// and the term tables that map each sum to its pair of factors.
package ppne_pkg;

    localparam int NUM_TERMS = 6;
    localparam int NUM_SUMS  = 27;
    localparam int IDX_W     = 5;
    localparam int JW        = 32;   // Q.16 Jacobian entry width

    // Term code 6 selects the residual instead of a Jacobian entry
    typedef logic [2:0] t_term;
    localparam t_term TERM_RES = 3'd6;

    localparam t_term TERM_A [NUM_SUMS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3,
        3'd4, 3'd4,
        3'd5,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
    };
    localparam t_term TERM_B [NUM_SUMS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd2, 3'd3, 3'd4, 3'd5,
        3'd3, 3'd4, 3'd5,
        3'd4, 3'd5,
        3'd5,
        TERM_RES, TERM_RES, TERM_RES, TERM_RES, TERM_RES, TERM_RES
    };

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SUMS - 1);

    // One classified correspondence: rounded Jacobian row, residual, clip flags
    typedef struct packed {
        logic [NUM_TERMS-1:0][JW-1:0] j;
        logic [JW-1:0]                r;
        logic [NUM_TERMS-1:0]         jc;
        logic                         rc;
        logic                         last;
    } t_jrow;

endpackage

### hdl/point_plane_normal_equations_unit.sv
// Top level of the point-to-plane normal-equation unit: stream ports,
// front end, row queue and back end. Depends on ppne_pkg and the ppne_* modules.
//
// In the back end each correspondence is loaded in the idle state, then one
// shared 32x32 multiplier computes the 21 J'J terms and 6 J'r terms one per
// cycle. The front end takes a new item every cycle while the queue is not
// full and two more rows wait in the queue, so items arrive in bursts; the
// back end pops a row only when idle. After the item marked tlast it passes
// a drain state, then emits the 27 sums (index in tuser) at one per cycle
// while the output is ready, clearing each sum as it goes; tlast marks index 26.
module point_plane_normal_equations_unit #(
    parameter int COORD_WIDTH  = 18,
    parameter int NORMAL_WIDTH = 16,
    parameter int ACC_WIDTH    = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // src_x, src_y, src_z, src_w, dst_x, dst_y, dst_z, nrm_x, nrm_y, nrm_z
    input  logic [((7*COORD_WIDTH+3*NORMAL_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic                                   i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // entry_value
    output logic [63:0]                            o_m_axis_tdata,
    // entry_index, entry_saturated
    output logic [7:0]                             o_m_axis_tuser,
    output logic                                   o_m_axis_tlast
);
    import ppne_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int NW = NORMAL_WIDTH;
    localparam int NB = 7 * CW;

    t_jrow            f_row, q_row;
    logic             f_push, q_full, q_empty, b_pop, o_sat;
    logic [IDX_W-1:0] o_idx;

    ppne_front #(
        .COORD_WIDTH  (COORD_WIDTH),
        .NORMAL_WIDTH (NORMAL_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_src_x ($signed(i_s_axis_tdata[0*CW +: CW])),
        .i_src_y ($signed(i_s_axis_tdata[1*CW +: CW])),
        .i_src_z ($signed(i_s_axis_tdata[2*CW +: CW])),
        .i_src_w ($signed(i_s_axis_tdata[3*CW +: CW])),
        .i_dst_x ($signed(i_s_axis_tdata[4*CW +: CW])),
        .i_dst_y ($signed(i_s_axis_tdata[5*CW +: CW])),
        .i_dst_z ($signed(i_s_axis_tdata[6*CW +: CW])),
        .i_nrm_x ($signed(i_s_axis_tdata[NB +: NW])),
        .i_nrm_y ($signed(i_s_axis_tdata[NB + NW +: NW])),
        .i_nrm_z ($signed(i_s_axis_tdata[NB + 2*NW +: NW])),
        .i_last  (i_s_axis_tlast),
        .o_push  (f_push),
        .i_full  (q_full),
        .o_row   (f_row)
    );

    ppne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_row   (f_row),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_empty (q_empty),
        .o_row   (q_row)
    );

    ppne_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_row   (q_row),
        .o_pop   (b_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_index (o_idx),
        .o_value (o_m_axis_tdata),
        .o_sat   (o_sat),
        .o_last  (o_m_axis_tlast)
    );

    // Pack index and saturation flag, zero-fill to a byte
    assign o_m_axis_tuser = {2'b00, o_sat, o_idx};

endmodule

### hdl/ppne_front.sv
// Front end: accepts correspondences, forms the products, then rounds the
// Jacobian row and residual to Q.16 with clipping. Uses ppne_pkg.
module ppne_front #(
    parameter int COORD_WIDTH  = 18,
    parameter int NORMAL_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [COORD_WIDTH-1:0]  i_src_x,
    input  logic signed [COORD_WIDTH-1:0]  i_src_y,
    input  logic signed [COORD_WIDTH-1:0]  i_src_z,
    input  logic signed [COORD_WIDTH-1:0]  i_src_w,
    input  logic signed [COORD_WIDTH-1:0]  i_dst_x,
    input  logic signed [COORD_WIDTH-1:0]  i_dst_y,
    input  logic signed [COORD_WIDTH-1:0]  i_dst_z,
    input  logic signed [NORMAL_WIDTH-1:0] i_nrm_x,
    input  logic signed [NORMAL_WIDTH-1:0] i_nrm_y,
    input  logic signed [NORMAL_WIDTH-1:0] i_nrm_z,
    input  logic                           i_last,
    output logic                           o_push,
    input  logic                           i_full,
    output ppne_pkg::t_jrow                o_row
);
    import ppne_pkg::*;

    localparam int PW = COORD_WIDTH + NORMAL_WIDTH;
    localparam int SW = PW + 3;
    localparam int NP = 15;

    function automatic logic [JW:0] f_q16(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        logic signed [63:0]   w;
        logic                 clip;
        logic [JW-1:0]        q;
        t = (v + SW'(512)) >>> 10;
        w = 64'(t);
        clip = 1'b0;
        q = w[JW-1:0];
        if (w > 64'sd2147483647) begin
            clip = 1'b1;
            q = {1'b0, {(JW-1){1'b1}}};
        end else if (w < -64'sd2147483648) begin
            clip = 1'b1;
            q = {1'b1, {(JW-1){1'b0}}};
        end
        return {clip, q};
    endfunction

    logic                 r_v1, r_v2;
    logic                 r_last1;
    logic signed [PW-1:0] r_pr [NP];
    t_jrow                r_row;
    logic signed [PW-1:0] pr [NP];
    logic signed [SW-1:0] ex [NP];
    logic signed [SW-1:0] raw [NUM_TERMS];
    logic signed [SW-1:0] res;
    logic [JW:0]          qj [NUM_TERMS];
    logic [JW:0]          qr;
    logic                 adv1, adv2;

    // Stage advance: stage 2 drains into the queue, stage 1 into stage 2
    assign adv2    = r_v2 && !i_full;
    assign adv1    = !r_v2 || !i_full;
    assign o_ready = !r_v1 || adv1;
    assign o_push  = adv2;
    assign o_row   = r_row;

    // Form all coordinate-times-normal products
    always_comb begin
        pr[0]  = i_src_w * i_nrm_x;
        pr[1]  = i_src_w * i_nrm_y;
        pr[2]  = i_src_w * i_nrm_z;
        pr[3]  = i_src_y * i_nrm_x;
        pr[4]  = i_src_x * i_nrm_y;
        pr[5]  = i_src_z * i_nrm_y;
        pr[6]  = i_src_y * i_nrm_z;
        pr[7]  = i_src_x * i_nrm_z;
        pr[8]  = i_src_z * i_nrm_x;
        pr[9]  = i_src_x * i_nrm_x;
        pr[10] = i_src_y * i_nrm_y;
        pr[11] = i_src_z * i_nrm_z;
        pr[12] = i_dst_x * i_nrm_x;
        pr[13] = i_dst_y * i_nrm_y;
        pr[14] = i_dst_z * i_nrm_z;
    end

    // Combine products into the raw row and residual, then round and clip
    always_comb begin
        for (int i = 0; i < NP; i++) begin
            ex[i] = SW'(r_pr[i]);
        end
        raw[0] = ex[0];
        raw[1] = ex[1];
        raw[2] = ex[2];
        raw[3] = ex[3] - ex[4];
        raw[4] = ex[5] - ex[6];
        raw[5] = ex[7] - ex[8];
        res    = ex[9] + ex[10] + ex[11] - ex[12] - ex[13] - ex[14];
        for (int i = 0; i < NUM_TERMS; i++) begin
            qj[i] = f_q16(raw[i]);
        end
        qr = f_q16(res);
    end

    // Advance the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (adv1) begin
                r_v2 <= r_v1;
            end
        end
        if (o_ready && i_valid) begin
            r_pr    <= pr;
            r_last1 <= i_last;
        end
        if (adv1 && r_v1) begin
            for (int i = 0; i < NUM_TERMS; i++) begin
                r_row.j[i]  <= qj[i][JW-1:0];
                r_row.jc[i] <= qj[i][JW];
            end
            r_row.r    <= qr[JW-1:0];
            r_row.rc   <= qr[JW];
            r_row.last <= r_last1;
        end
    end

endmodule

### hdl/ppne_queue.sv
// Two-entry queue of Jacobian rows between front end and back end.
// Uses the row record from ppne_pkg.
module ppne_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppne_pkg::t_jrow i_row,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ppne_pkg::t_jrow o_row
);
    import ppne_pkg::*;

    t_jrow      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_row   = r_mem[r_rp];

    // Store on push, advance read side on pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_row;
        end
    end

endmodule

### hdl/ppne_back.sv
// Back end: walks the 27 sums with one shared 32x32 multiplier and a
// saturating accumulator, then emits and clears the sums. Uses ppne_pkg.
module ppne_back #(
    parameter int ACC_WIDTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  ppne_pkg::t_jrow                i_row,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ppne_pkg::IDX_W-1:0]     o_index,
    output logic [63:0]                    o_value,
    output logic                           o_sat,
    output logic                           o_last
);
    import ppne_pkg::*;

    localparam logic signed [65:0] AMAX = (66'sd1 <<< (ACC_WIDTH - 1)) - 66'sd1;
    localparam logic signed [65:0] AMIN = -AMAX - 66'sd1;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_EMIT} t_state;

    t_state                      r_state;
    t_jrow                       r_row;
    logic [IDX_W-1:0]            r_cnt;
    logic                        r_pv, r_pneg, r_pclip;
    logic [IDX_W-1:0]            r_pk;
    logic signed [63:0]          r_p;
    logic signed [ACC_WIDTH-1:0] r_sum [NUM_SUMS];
    logic                        r_sat [NUM_SUMS];
    logic                        r_ovalid, r_osat, r_olast;
    logic [IDX_W-1:0]            r_oidx;
    logic [63:0]                 r_oval;

    t_term                       ta, tb;
    logic signed [JW-1:0]        fa, fb;
    logic                        ca, cb;
    logic signed [63:0]          padd;
    logic signed [65:0]          s66;
    logic signed [ACC_WIDTH-1:0] snext;
    logic                        ovf;
    logic                        oslot;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign oslot   = !r_ovalid || i_ready;
    assign o_valid = r_ovalid;
    assign o_index = r_oidx;
    assign o_value = r_oval;
    assign o_sat   = r_osat;
    assign o_last  = r_olast;

    // Select the two factors of the current sum
    always_comb begin
        ta = TERM_A[r_cnt];
        tb = TERM_B[r_cnt];
        fa = $signed(r_row.j[ta]);
        ca = r_row.jc[ta];
        if (tb == TERM_RES) begin
            fb = $signed(r_row.r);
            cb = r_row.rc;
        end else begin
            fb = $signed(r_row.j[tb]);
            cb = r_row.jc[tb];
        end
    end

    // Saturating add of the registered product
    always_comb begin
        padd  = r_pneg ? -r_p : r_p;
        s66   = 66'(r_sum[r_pk]) + 66'(padd);
        ovf   = 1'b0;
        snext = s66[ACC_WIDTH-1:0];
        if (s66 > AMAX) begin
            ovf   = 1'b1;
            snext = AMAX[ACC_WIDTH-1:0];
        end else if (s66 < AMIN) begin
            ovf   = 1'b1;
            snext = AMIN[ACC_WIDTH-1:0];
        end
    end

    // Sequence issue, accumulation and emission
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NUM_SUMS; k++) begin
                r_sum[k] <= '0;
                r_sat[k] <= 1'b0;
            end
        end else begin
            r_pv <= (r_state == S_RUN);
            if (r_pv) begin
                r_sum[r_pk] <= snext;
                if (ovf || r_pclip) begin
                    r_sat[r_pk] <= 1'b1;
                end
            end
            if (oslot) begin
                r_ovalid <= (r_state == S_EMIT);
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_row   <= i_row;
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_pk    <= r_cnt;
                    r_p     <= fa * fb;
                    r_pneg  <= (tb == TERM_RES);
                    r_pclip <= ca || cb;
                    if (r_cnt == LAST_IDX) begin
                        r_cnt   <= '0;
                        r_state <= r_row.last ? S_DRAIN : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (oslot) begin
                        r_oidx       <= r_cnt;
                        r_oval       <= 64'(r_sum[r_cnt]);
                        r_osat       <= r_sat[r_cnt];
                        r_olast      <= (r_cnt == LAST_IDX);
                        r_sum[r_cnt] <= '0;
                        r_sat[r_cnt] <= 1'b0;
                        if (r_cnt == LAST_IDX) begin
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
